### rtl/core/first_fit_arena_allocator_macros.svh
// assertion macros shared by the allocator rtl
// no dependencies; include by bare file name
`ifndef FIRST_FIT_ARENA_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_ARENA_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define FFAA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define FFAA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/ffaa_pkg.sv
// constants, types and codes of the first-fit arena allocator
// no dependencies
`timescale 1ns / 1ps

package ffaa_pkg;

   localparam int ARENA_BYTES = 1048576;
   localparam int MAX_BLOCKS  = 64;

   localparam int FIELD_W = 24;
   localparam int SIZE_W  = FIELD_W + 1;
   localparam int START_W = $clog2(ARENA_BYTES);
   localparam int LEN_W   = START_W + 1;
   localparam int END_W   = LEN_W + 1;
   localparam int SUM_W   = END_W + 1;
   localparam int ENTRY_W = START_W + LEN_W;
   localparam int ADDR_W  = $clog2(MAX_BLOCKS);
   localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
   localparam int STAT_W  = 2;

   localparam logic [2:0] ALIGN_MASK = 3'h7;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOMEM   = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STAT_W-1:0] ST_IGNORED = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_ALLOC_CHK,
      S_FREE_CHK,
      S_APPEND,
      S_INS_START,
      S_INS,
      S_INS_PUT,
      S_REMOVE,
      S_DONE
   } state_type;

endpackage

### rtl/core/ffaa_ifs.sv
// request and response channel interfaces of the allocator
// depends on ffaa_pkg
`timescale 1ns / 1ps

interface ffaa_req_if;
   logic                         valid;
   logic                         ready;
   logic                         opcode;
   logic [ffaa_pkg::FIELD_W-1:0] req_size;
   logic [ffaa_pkg::FIELD_W-1:0] free_offset;
   modport source (output valid, opcode, req_size, free_offset, input ready);
   modport sink   (input valid, opcode, req_size, free_offset, output ready);
endinterface

interface ffaa_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ffaa_pkg::STAT_W-1:0]  status;
   logic [ffaa_pkg::START_W-1:0] block_offset;
   modport source (output valid, status, block_offset, input ready);
   modport sink   (input valid, status, block_offset, output ready);
endinterface

### rtl/core/ffaa_ram.sv
// generic single-write, single-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module ffaa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/first_fit_arena_allocator.sv
// first-fit arena allocator top level: sorted block table in ram, scan and shift sequencer
// depends on ffaa_pkg, ffaa_ifs, ffaa_ram, first_fit_arena_allocator_macros.svh
//
//   channel   dir  fields                          item
//   req_if    in   opcode, req_size, free_offset   one alloc or free request
//   rsp_if    out  status, block_offset            one result per request
//
// one request at a time; the table ram has one read and one write port
// alloc: scan, then shift and write
// free: scan, then shift down
// the sequencer returns to idle after each result before the next item is taken
// synchronous reset empties the table and clears the bump pointer; no clearing pass
// a held result stalls only the item behind it, at its final step
`timescale 1ns / 1ps
`include "first_fit_arena_allocator_macros.svh"

module first_fit_arena_allocator (
   input  logic       clock,
   input  logic       reset,
   ffaa_req_if.sink   req_if,
   ffaa_rsp_if.source rsp_if
);

   ffaa_pkg::state_type state_ff, state_in;

   logic [ffaa_pkg::LEN_W-1:0]   size_ff, size_in;
   logic [ffaa_pkg::FIELD_W-1:0] off_ff, off_in;
   logic [ffaa_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [ffaa_pkg::LEN_W-1:0]   bump_ff, bump_in;
   logic [ffaa_pkg::CNT_W-1:0]   idx_ff, idx_in;
   logic [ffaa_pkg::CNT_W-1:0]   pos_ff, pos_in;
   logic [ffaa_pkg::END_W-1:0]   prev_end_ff, prev_end_in;
   logic [ffaa_pkg::START_W-1:0] new_start_ff, new_start_in;
   logic [ffaa_pkg::STAT_W-1:0]  status_ff, status_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [ffaa_pkg::STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [ffaa_pkg::START_W-1:0] rsp_offset_ff, rsp_offset_in;

   logic                         wr_en;
   logic [ffaa_pkg::ADDR_W-1:0]  wr_addr, rd_addr;
   logic [ffaa_pkg::ENTRY_W-1:0] wr_data, rd_data;

   logic [ffaa_pkg::START_W-1:0] d_start;
   logic [ffaa_pkg::LEN_W-1:0]   d_len;
   logic [ffaa_pkg::END_W-1:0]   d_end;
   logic [ffaa_pkg::SUM_W-1:0]   need;
   logic                         fit;
   logic [ffaa_pkg::SIZE_W-1:0]  rounded;
   logic [ffaa_pkg::END_W-1:0]   bump_sum;
   logic                         append_fail;
   logic [ffaa_pkg::CNT_W-1:0]   idx_next;
   logic                         req_fire, rsp_free;

   ffaa_ram #(
      .WIDTH(ffaa_pkg::ENTRY_W),
      .DEPTH(ffaa_pkg::MAX_BLOCKS)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_if.ready = (state_ff == ffaa_pkg::S_IDLE);
   assign req_fire     = req_if.valid && req_if.ready;
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.status       = rsp_status_ff;
   assign rsp_if.block_offset = rsp_offset_ff;

   // rounding and scan datapath
   assign rounded = (ffaa_pkg::SIZE_W'(req_if.req_size) + ffaa_pkg::SIZE_W'(ffaa_pkg::ALIGN_MASK))
                    & ~ffaa_pkg::SIZE_W'(ffaa_pkg::ALIGN_MASK);
   assign d_start  = rd_data[ffaa_pkg::ENTRY_W-1 -: ffaa_pkg::START_W];
   assign d_len    = rd_data[ffaa_pkg::LEN_W-1:0];
   assign d_end    = ffaa_pkg::END_W'(d_start) + ffaa_pkg::END_W'(d_len);
   assign need     = ffaa_pkg::SUM_W'(prev_end_ff) + ffaa_pkg::SUM_W'(size_ff);
   assign fit      = (idx_ff == '0) ? (ffaa_pkg::LEN_W'(d_start) > size_ff)
                                    : (ffaa_pkg::SUM_W'(d_start) >= need);
   assign bump_sum = ffaa_pkg::END_W'(bump_ff) + ffaa_pkg::END_W'(size_ff);
   assign append_fail = (bump_ff >= ffaa_pkg::LEN_W'(ffaa_pkg::ARENA_BYTES))
                     || (bump_sum > ffaa_pkg::END_W'(ffaa_pkg::ARENA_BYTES));
   assign idx_next = ffaa_pkg::CNT_W'(idx_ff + 1'b1);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ffaa_pkg::S_IDLE: begin
            if (req_fire) begin
               if (req_if.opcode == ffaa_pkg::OP_ALLOC) begin
                  if (rounded > ffaa_pkg::SIZE_W'(ffaa_pkg::ARENA_BYTES)) begin
                     state_in = ffaa_pkg::S_DONE;
                  end else if (cnt_ff >= ffaa_pkg::CNT_W'(ffaa_pkg::MAX_BLOCKS)) begin
                     state_in = ffaa_pkg::S_DONE;
                  end else if (cnt_ff == '0) begin
                     state_in = ffaa_pkg::S_APPEND;
                  end else begin
                     state_in = ffaa_pkg::S_ALLOC_CHK;
                  end
               end else begin
                  if (req_if.free_offset > ffaa_pkg::FIELD_W'(ffaa_pkg::ARENA_BYTES)
                      || cnt_ff == '0) begin
                     state_in = ffaa_pkg::S_DONE;
                  end else begin
                     state_in = ffaa_pkg::S_FREE_CHK;
                  end
               end
            end
         end
         ffaa_pkg::S_ALLOC_CHK: begin
            if (fit) begin
               state_in = ffaa_pkg::S_INS_START;
            end else if (idx_next == cnt_ff) begin
               state_in = ffaa_pkg::S_APPEND;
            end
         end
         ffaa_pkg::S_APPEND: begin
            state_in = append_fail ? ffaa_pkg::S_DONE : ffaa_pkg::S_INS_START;
         end
         ffaa_pkg::S_INS_START: begin
            state_in = (pos_ff == cnt_ff) ? ffaa_pkg::S_DONE : ffaa_pkg::S_INS;
         end
         ffaa_pkg::S_INS: begin
            if (ffaa_pkg::CNT_W'(idx_ff - 1'b1) == pos_ff) begin
               state_in = ffaa_pkg::S_INS_PUT;
            end
         end
         ffaa_pkg::S_INS_PUT: begin
            state_in = ffaa_pkg::S_DONE;
         end
         ffaa_pkg::S_FREE_CHK: begin
            if (ffaa_pkg::FIELD_W'(d_start) == off_ff) begin
               state_in = (idx_next < cnt_ff) ? ffaa_pkg::S_REMOVE : ffaa_pkg::S_DONE;
            end else if (idx_next == cnt_ff) begin
               state_in = ffaa_pkg::S_DONE;
            end
         end
         ffaa_pkg::S_REMOVE: begin
            if (ffaa_pkg::CNT_W'(idx_ff + 2'd2) >= cnt_ff) begin
               state_in = ffaa_pkg::S_DONE;
            end
         end
         ffaa_pkg::S_DONE: begin
            if (rsp_free) begin
               state_in = ffaa_pkg::S_IDLE;
            end
         end
         default: state_in = ffaa_pkg::S_IDLE;
      endcase
   end

   // datapath and table control
   always_comb begin
      size_in       = size_ff;
      off_in        = off_ff;
      cnt_in        = cnt_ff;
      bump_in       = bump_ff;
      idx_in        = idx_ff;
      pos_in        = pos_ff;
      prev_end_in   = prev_end_ff;
      new_start_in  = new_start_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[ffaa_pkg::ADDR_W-1:0];
      wr_data       = rd_data;
      rd_addr       = '0;
      case (state_ff)
         ffaa_pkg::S_IDLE: begin
            size_in      = rounded[ffaa_pkg::LEN_W-1:0];
            off_in       = req_if.free_offset;
            idx_in       = '0;
            new_start_in = '0;
            status_in    = ffaa_pkg::ST_OK;
            if (req_if.opcode == ffaa_pkg::OP_ALLOC) begin
               if (rounded > ffaa_pkg::SIZE_W'(ffaa_pkg::ARENA_BYTES)) begin
                  status_in = ffaa_pkg::ST_NOMEM;
               end else if (cnt_ff >= ffaa_pkg::CNT_W'(ffaa_pkg::MAX_BLOCKS)) begin
                  status_in = ffaa_pkg::ST_FULL;
               end
            end else if (req_if.free_offset > ffaa_pkg::FIELD_W'(ffaa_pkg::ARENA_BYTES)
                         || cnt_ff == '0) begin
               status_in = ffaa_pkg::ST_IGNORED;
            end
         end
         ffaa_pkg::S_ALLOC_CHK: begin
            rd_addr = idx_next[ffaa_pkg::ADDR_W-1:0];
            if (fit) begin
               pos_in       = idx_ff;
               new_start_in = (idx_ff == '0) ? '0 : prev_end_ff[ffaa_pkg::START_W-1:0];
            end else begin
               prev_end_in = d_end;
               idx_in      = idx_next;
            end
         end
         ffaa_pkg::S_APPEND: begin
            if (append_fail) begin
               status_in = ffaa_pkg::ST_NOMEM;
            end else begin
               new_start_in = bump_ff[ffaa_pkg::START_W-1:0];
               pos_in       = cnt_ff;
               bump_in      = bump_sum[ffaa_pkg::LEN_W-1:0];
            end
         end
         ffaa_pkg::S_INS_START: begin
            rd_addr = ffaa_pkg::ADDR_W'(cnt_ff - 1'b1);
            idx_in  = cnt_ff;
            if (pos_ff == cnt_ff) begin
               wr_en   = 1'b1;
               wr_addr = pos_ff[ffaa_pkg::ADDR_W-1:0];
               wr_data = {new_start_ff, size_ff};
               cnt_in  = ffaa_pkg::CNT_W'(cnt_ff + 1'b1);
            end
         end
         ffaa_pkg::S_INS: begin
            wr_en   = 1'b1;
            rd_addr = ffaa_pkg::ADDR_W'(idx_ff - 2'd2);
            idx_in  = ffaa_pkg::CNT_W'(idx_ff - 1'b1);
         end
         ffaa_pkg::S_INS_PUT: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff[ffaa_pkg::ADDR_W-1:0];
            wr_data = {new_start_ff, size_ff};
            cnt_in  = ffaa_pkg::CNT_W'(cnt_ff + 1'b1);
         end
         ffaa_pkg::S_FREE_CHK: begin
            rd_addr = idx_next[ffaa_pkg::ADDR_W-1:0];
            if (ffaa_pkg::FIELD_W'(d_start) == off_ff) begin
               if (idx_next >= cnt_ff) begin
                  cnt_in = ffaa_pkg::CNT_W'(cnt_ff - 1'b1);
               end
            end else if (idx_next == cnt_ff) begin
               status_in = ffaa_pkg::ST_IGNORED;
            end else begin
               idx_in = idx_next;
            end
         end
         ffaa_pkg::S_REMOVE: begin
            wr_en   = 1'b1;
            rd_addr = ffaa_pkg::ADDR_W'(idx_ff + 2'd2);
            idx_in  = idx_next;
            if (ffaa_pkg::CNT_W'(idx_ff + 2'd2) >= cnt_ff) begin
               cnt_in = ffaa_pkg::CNT_W'(cnt_ff - 1'b1);
            end
         end
         ffaa_pkg::S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_offset_in = (status_ff == ffaa_pkg::ST_OK) ? new_start_ff : '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffaa_pkg::S_IDLE;
         cnt_ff       <= '0;
         bump_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         bump_ff      <= bump_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      size_ff       <= size_in;
      off_ff        <= off_in;
      idx_ff        <= idx_in;
      pos_ff        <= pos_in;
      prev_end_ff   <= prev_end_in;
      new_start_ff  <= new_start_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   `FFAA_ASSERT_NOW(a_cnt_bound, clock, reset, 1'b1,
      cnt_ff <= ffaa_pkg::CNT_W'(ffaa_pkg::MAX_BLOCKS), "block count above table depth")
   `FFAA_ASSERT_NOW(a_bump_bound, clock, reset, 1'b1,
      bump_ff <= ffaa_pkg::LEN_W'(ffaa_pkg::ARENA_BYTES), "bump pointer beyond arena")
   `FFAA_ASSERT_NOW(a_idle_no_write, clock, reset, state_ff == ffaa_pkg::S_IDLE,
      !wr_en, "table written while idle")
   `FFAA_ASSERT_NEXT(a_accept_busy, clock, reset, req_fire,
      state_ff != ffaa_pkg::S_IDLE, "accepted item not processed")
   `FFAA_ASSERT_NOW(a_fail_zero_offset, clock, reset,
      rsp_valid_ff && rsp_status_ff != ffaa_pkg::ST_OK,
      rsp_offset_ff == '0, "failed item carries an offset")

endmodule

### dv/ffaa_tb_ifs.sv
// testbench types: one expected response item and one row of the directed stimulus table
// depends on ffaa_pkg; channel interfaces come from the rtl ffaa_ifs file
`timescale 1ns / 1ps

package ffaa_tb_pkg;

   typedef struct packed {
      logic [ffaa_pkg::STAT_W-1:0]  status;
      logic [ffaa_pkg::START_W-1:0] block_offset;
   } rsp_item_type;

   typedef struct packed {
      logic                         opcode;
      logic [ffaa_pkg::FIELD_W-1:0] req_size;
      logic [ffaa_pkg::FIELD_W-1:0] free_offset;
      logic                         has_fixed;
      rsp_item_type                 fixed;
   } stim_row_type;

endpackage

### dv/first_fit_arena_allocator_tb.sv
// testbench of the first-fit arena allocator: directed table then random alloc/free traffic
// checks every response against a behavioral allocator; depends on ffaa_pkg, ffaa_ifs, ffaa_tb_pkg
`timescale 1ns / 1ps

module first_fit_arena_allocator_tb;

   localparam int unsigned DIR_ROWS    = 20;
   localparam int unsigned RAND_ITEMS  = 1630;
   localparam int unsigned CALM_ITEMS  = 200;
   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned ARENA       = ffaa_pkg::ARENA_BYTES;

   logic clock;
   logic reset;
   ffaa_req_if req_if ();
   ffaa_rsp_if rsp_if ();

   first_fit_arena_allocator DUT (
      .clock(clock), .reset(reset), .req_if(req_if.sink), .rsp_if(rsp_if.source)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // behavioral allocator state
   int unsigned blk_start [ffaa_pkg::MAX_BLOCKS];
   int unsigned blk_len   [ffaa_pkg::MAX_BLOCKS];
   int unsigned blk_count;
   int unsigned bump;

   ffaa_tb_pkg::rsp_item_type exp_q [$];
   ffaa_tb_pkg::stim_row_type dir_rows [DIR_ROWS];
   ffaa_tb_pkg::stim_row_type drv_row;
   int unsigned mismatches;
   int unsigned rsp_seen;
   int unsigned sent;
   int unsigned cycles;
   int unsigned st_count [4];
   bit          calm;

   function automatic void table_insert(int unsigned pos, int unsigned s, int unsigned l);
      for (int unsigned i = blk_count; i > pos; i--) begin
         blk_start[i] = blk_start[i-1];
         blk_len[i]   = blk_len[i-1];
      end
      blk_start[pos] = s;
      blk_len[pos]   = l;
      blk_count++;
   endfunction

   function automatic ffaa_tb_pkg::rsp_item_type predict_alloc(int unsigned req);
      ffaa_tb_pkg::rsp_item_type r;
      int unsigned sz;
      int unsigned prev_end;
      r = '0;
      sz = (req + 7) & ~32'h7;
      if (sz > ARENA) begin
         r.status = ffaa_pkg::ST_NOMEM;
         return r;
      end
      if (blk_count >= ffaa_pkg::MAX_BLOCKS) begin
         r.status = ffaa_pkg::ST_FULL;
         return r;
      end
      if (blk_count > 0) begin
         if (blk_start[0] > sz) begin
            table_insert(0, 0, sz);
            r.status = ffaa_pkg::ST_OK;
            return r;
         end
         for (int unsigned i = 1; i < blk_count; i++) begin
            prev_end = blk_start[i-1] + blk_len[i-1];
            if (blk_start[i] >= prev_end + sz) begin
               table_insert(i, prev_end, sz);
               r.status = ffaa_pkg::ST_OK;
               r.block_offset = ffaa_pkg::START_W'(prev_end);
               return r;
            end
         end
      end
      if (bump >= ARENA || bump + sz > ARENA) begin
         r.status = ffaa_pkg::ST_NOMEM;
         return r;
      end
      r.status = ffaa_pkg::ST_OK;
      r.block_offset = ffaa_pkg::START_W'(bump);
      table_insert(blk_count, bump, sz);
      bump += sz;
      return r;
   endfunction

   function automatic ffaa_tb_pkg::rsp_item_type predict_free(int unsigned off);
      ffaa_tb_pkg::rsp_item_type r;
      r = '0;
      r.status = ffaa_pkg::ST_IGNORED;
      if (off > ARENA) return r;
      for (int unsigned i = 0; i < blk_count; i++) begin
         if (blk_start[i] == off) begin
            for (int unsigned j = i; j + 1 < blk_count; j++) begin
               blk_start[j] = blk_start[j+1];
               blk_len[j]   = blk_len[j+1];
            end
            blk_count--;
            r.status = ffaa_pkg::ST_OK;
            return r;
         end
      end
      return r;
   endfunction

   function automatic ffaa_tb_pkg::stim_row_type mk_row(input logic op, input int unsigned size,
         input int unsigned off, input logic has_fixed,
         input logic [ffaa_pkg::STAT_W-1:0] st);
      ffaa_tb_pkg::stim_row_type r;
      r = '0;
      r.opcode             = op;
      r.req_size           = ffaa_pkg::FIELD_W'(size);
      r.free_offset        = ffaa_pkg::FIELD_W'(off);
      r.has_fixed          = has_fixed;
      r.fixed.status       = st;
      r.fixed.block_offset = '0;
      return r;
   endfunction

   // accepted requests are predicted at the edge they are taken
   always @(posedge clock) begin
      ffaa_tb_pkg::rsp_item_type e;
      ffaa_tb_pkg::rsp_item_type p;
      cycles <= cycles + 1;
      if (!reset && req_if.valid && req_if.ready) begin
         if (req_if.opcode == ffaa_pkg::OP_ALLOC)
            p = predict_alloc(32'(req_if.req_size));
         else
            p = predict_free(32'(req_if.free_offset));
         if (drv_row.has_fixed)
            p = drv_row.fixed;
         exp_q.insert(exp_q.size(), p);
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         rsp_seen++;
         st_count[rsp_if.status]++;
         if (exp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response status=%0d offset=%0h",
                        rsp_if.status, rsp_if.block_offset);
         end else begin
            e = exp_q.pop_front();
            if (e.status !== rsp_if.status || e.block_offset !== rsp_if.block_offset) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp status=%0d offset=%0h, got status=%0d offset=%0h",
                           e.status, e.block_offset, rsp_if.status, rsp_if.block_offset);
            end
         end
      end
   end

   task automatic send_item(input ffaa_tb_pkg::stim_row_type rw);
      int unsigned n;
      req_if.valid       <= 1'b1;
      req_if.opcode      <= rw.opcode;
      req_if.req_size    <= rw.req_size;
      req_if.free_offset <= rw.free_offset;
      drv_row            <= rw;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sent++;
      if (!calm && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 6);
         req_if.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // sender pauses until every expected result has come
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (exp_q.size() != 0) @(posedge clock);
   endtask

   // stimulus
   initial begin
      ffaa_tb_pkg::stim_row_type rw;
      int unsigned pick;
      int unsigned size;
      int unsigned off;
      reset              <= 1'b1;
      req_if.valid       <= 1'b0;
      req_if.opcode      <= ffaa_pkg::OP_ALLOC;
      req_if.req_size    <= '0;
      req_if.free_offset <= '0;
      drv_row            <= '0;
      calm = 1'b0;

      dir_rows[0]  = mk_row(ffaa_pkg::OP_FREE,  0,        0,        1'b1, ffaa_pkg::ST_IGNORED);
      dir_rows[1]  = mk_row(ffaa_pkg::OP_FREE,  0,        32'h100001, 1'b1, ffaa_pkg::ST_IGNORED);
      dir_rows[2]  = mk_row(ffaa_pkg::OP_ALLOC, 32'hFFFFFF, 0,      1'b1, ffaa_pkg::ST_NOMEM);
      dir_rows[3]  = mk_row(ffaa_pkg::OP_ALLOC, 32'h100001, 0,      1'b1, ffaa_pkg::ST_NOMEM);
      dir_rows[4]  = mk_row(ffaa_pkg::OP_ALLOC, 1,        0,        1'b1, ffaa_pkg::ST_OK);
      dir_rows[5]  = mk_row(ffaa_pkg::OP_ALLOC, 13,       0,        1'b0, ffaa_pkg::ST_OK);
      dir_rows[6]  = mk_row(ffaa_pkg::OP_FREE,  0,        8,        1'b0, ffaa_pkg::ST_OK);
      dir_rows[7]  = mk_row(ffaa_pkg::OP_ALLOC, 8,        0,        1'b0, ffaa_pkg::ST_OK);
      dir_rows[8]  = mk_row(ffaa_pkg::OP_ALLOC, 16,       0,        1'b0, ffaa_pkg::ST_OK);
      dir_rows[9]  = mk_row(ffaa_pkg::OP_FREE,  0,        0,        1'b0, ffaa_pkg::ST_OK);
      dir_rows[10] = mk_row(ffaa_pkg::OP_ALLOC, 0,        0,        1'b0, ffaa_pkg::ST_OK);
      dir_rows[11] = mk_row(ffaa_pkg::OP_ALLOC, 0,        0,        1'b0, ffaa_pkg::ST_OK);
      dir_rows[12] = mk_row(ffaa_pkg::OP_FREE,  0,        0,        1'b0, ffaa_pkg::ST_OK);
      dir_rows[13] = mk_row(ffaa_pkg::OP_FREE,  0,        0,        1'b0, ffaa_pkg::ST_OK);
      dir_rows[14] = mk_row(ffaa_pkg::OP_FREE,  0,        0,        1'b0, ffaa_pkg::ST_OK);
      dir_rows[15] = mk_row(ffaa_pkg::OP_FREE,  0,        8,        1'b0, ffaa_pkg::ST_OK);
      dir_rows[16] = mk_row(ffaa_pkg::OP_FREE,  0,        24,       1'b0, ffaa_pkg::ST_OK);
      dir_rows[17] = mk_row(ffaa_pkg::OP_ALLOC, ARENA,    0,        1'b0, ffaa_pkg::ST_OK);
      dir_rows[18] = mk_row(ffaa_pkg::OP_FREE,  0,        ARENA,    1'b0, ffaa_pkg::ST_OK);
      dir_rows[19] = mk_row(ffaa_pkg::OP_ALLOC, 7,        0,        1'b0, ffaa_pkg::ST_OK);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int unsigned i = 0; i < DIR_ROWS; i++) begin
         send_item(dir_rows[i]);
      end
      drain();

      for (int unsigned k = 0; k < RAND_ITEMS; k++) begin
         if (k == RAND_ITEMS - CALM_ITEMS) calm = 1'b1;
         if (k == RAND_ITEMS / 2) drain();
         rw = '0;
         pick = $urandom_range(0, 99);
         if ($urandom_range(0, 9) < 6) begin
            rw.opcode = ffaa_pkg::OP_ALLOC;
            if (pick < 5) size = 0;
            else if (pick < 80) size = $urandom_range(1, 2048);
            else if (pick < 90) size = $urandom_range(2049, 16384);
            else if (pick < 95) size = $urandom_range(ARENA + 1, 32'hFFFFFF);
            else if (k > 1300 && bump < ARENA) size = ARENA - bump;
            else size = $urandom_range(1, 64);
            rw.req_size = ffaa_pkg::FIELD_W'(size);
         end else begin
            rw.opcode = ffaa_pkg::OP_FREE;
            if (blk_count > 0 && pick < 80) off = blk_start[$urandom_range(0, blk_count - 1)];
            else if (pick < 90) off = $urandom_range(0, 32'hFFFFFF);
            else off = 8 * $urandom_range(0, ARENA / 8);
            rw.free_offset = ffaa_pkg::FIELD_W'(off);
         end
         send_item(rw);
      end
      drain();
      repeat (20) @(posedge clock);

      $display("run covered %0d items: %0d directed rows, then random alloc and free traffic",
               sent, DIR_ROWS);
      $display("responses: %0d ok, %0d out of memory, %0d table full, %0d free ignored",
               st_count[0], st_count[1], st_count[2], st_count[3]);
      if (mismatches == 0 && rsp_seen == sent && exp_q.size() == 0)
         $display("** first_fit_arena_allocator: PASSED **");
      else
         $display("** first_fit_arena_allocator: FAILED **");
      $finish;
   end

   // response side stalls in bursts
   initial begin
      int unsigned n;
      rsp_if.ready = 1'b0;
      @(posedge clock);
      while (!reset) @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 6);
            rsp_if.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // limit
   initial begin
      wait (cycles >= CYCLE_LIMIT);
      $display("** first_fit_arena_allocator: FAILED **");
      $finish;
   end
endmodule

### dv/first_fit_arena_allocator_tb_top.sv
// holds no module: the testbench top first_fit_arena_allocator_tb is in its own file
// depends on nothing
`timescale 1ns / 1ps

### filelist.f
+incdir+rtl/core
rtl/core/ffaa_pkg.sv
rtl/core/ffaa_ifs.sv
rtl/core/ffaa_ram.sv
rtl/core/first_fit_arena_allocator.sv
dv/ffaa_tb_ifs.sv
dv/first_fit_arena_allocator_tb.sv
dv/first_fit_arena_allocator_tb_top.sv
